FILE: rtl/lirc_pkg.sv
// Shared constants for the longest increasing run counter.
// Holds the sequencer state codes and the tuser bit positions; depends on nothing.
`default_nettype none

package lirc_pkg;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam int unsigned USER_SAT_BIT = 0;
    localparam int unsigned USER_OVF_BIT = 1;
    localparam int unsigned USER_BITS    = 2;

endpackage

`default_nettype wire

FILE: rtl/longest_increasing_run_counter.sv
// Top level of the longest increasing run counter: sequencer, scan pipeline and output register.
// Depends on lirc_pkg and lirc_entry_ram.
`default_nettype none

// Each accepted transaction carries one signed value; the block answers with exactly one
// transaction holding the length of the longest strictly increasing subsequence seen so far,
// the number of such subsequences (saturating), and the saturation and overflow flags in tuser.
// tlast on the input ends the sequence: its answer carries tlast and the stored sequence is
// cleared afterwards. An item that finds the store neither empty nor full is compared with every
// stored entry before its answer is formed; an item that finds the store empty or full skips
// that scan. The scan walks the single read port of the entry memory at one stored entry per
// cycle. The next item may be accepted while an earlier answer still waits on the output.
module longest_increasing_run_counter
    import lirc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS  = 2048,
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0: value.
    input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  wire logic                                s_tlast,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // Fields from bit 0: longest_len, longest_count.
    output logic [(($clog2(MAX_ITEMS + 1) + COUNT_BITS + 7) / 8) * 8-1:0] m_tdata,
    // Fields from bit 0: count_saturated, store_overflow.
    output logic [USER_BITS-1:0]                     m_tuser,
    output logic                                     m_tlast
);

    localparam int unsigned LEN_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned ADDR_BITS = $clog2(MAX_ITEMS);
    localparam int unsigned OUT_W     = ((LEN_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int unsigned ENTRY_W   = VALUE_BITS + LEN_BITS + COUNT_BITS;
    localparam logic [LEN_BITS-1:0]   FULL_LEVEL = LEN_BITS'(MAX_ITEMS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = {COUNT_BITS{1'b1}};

    logic [1:0]            state_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic                  last_reg;
    logic [LEN_BITS-1:0]   fill_reg;
    logic [LEN_BITS-1:0]   idx_reg;
    logic                  rd_valid_reg;
    logic                  cmp_valid_reg;
    logic                  cmp_hit_reg;
    logic [LEN_BITS-1:0]   cmp_len_reg;
    logic [COUNT_BITS-1:0] cmp_cnt_reg;
    logic [LEN_BITS-1:0]   acc_len_reg;
    logic [COUNT_BITS-1:0] acc_cnt_reg;
    logic [LEN_BITS-1:0]   best_len_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic                  sat_reg;
    logic                  ovf_reg;
    logic                  m_tvalid_reg;
    logic [LEN_BITS-1:0]   out_len_reg;
    logic [COUNT_BITS-1:0] out_cnt_reg;
    logic                  out_sat_reg;
    logic                  out_ovf_reg;
    logic                  out_last_reg;

    logic [VALUE_BITS-1:0] in_key;
    logic                  in_fire;
    logic                  rd_en;
    logic                  scan_done;
    logic                  fin_fire;
    logic                  store_full;
    logic [ENTRY_W-1:0]    rd_data;
    logic [VALUE_BITS-1:0] rd_key;
    logic [LEN_BITS-1:0]   rd_len;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS:0]   acc_sum;
    logic [COUNT_BITS:0]   best_sum;
    logic [LEN_BITS-1:0]   best_len_next;
    logic [COUNT_BITS-1:0] best_cnt_next;
    logic                  sat_next;
    logic                  ovf_next;

    // The sign bit is flipped so that an unsigned compare gives the signed order.
    assign in_key   = {~s_tdata[VALUE_BITS-1], s_tdata[VALUE_BITS-2:0]};
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign rd_en     = (state_reg == ST_SCAN) && (idx_reg != fill_reg);
    assign scan_done = (state_reg == ST_SCAN) && (idx_reg == fill_reg)
                       && !rd_valid_reg && !cmp_valid_reg;
    assign fin_fire  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign store_full = (fill_reg == FULL_LEVEL);

    assign {rd_key, rd_len, rd_cnt} = rd_data;

    assign acc_sum  = {1'b0, acc_cnt_reg} + {1'b0, cmp_cnt_reg};
    assign best_sum = {1'b0, best_cnt_reg} + {1'b0, acc_cnt_reg};

    always_comb
    begin
        best_len_next = best_len_reg;
        best_cnt_next = best_cnt_reg;
        sat_next      = sat_reg;
        ovf_next      = ovf_reg;
        if (store_full)
        begin
            ovf_next = 1'b1;
        end
        else if (acc_len_reg > best_len_reg)
        begin
            best_len_next = acc_len_reg;
            best_cnt_next = acc_cnt_reg;
        end
        else if (acc_len_reg == best_len_reg)
        begin
            best_cnt_next = best_sum[COUNT_BITS] ? CNT_MAX : best_sum[COUNT_BITS-1:0];
            sat_next      = sat_reg || best_sum[COUNT_BITS];
        end
    end

    // Reads cover only entries below the fill level and the write lands at the fill level
    // after the scan has drained, so a read and a write never meet on one entry.
    lirc_entry_ram #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (fin_fire && !store_full),
        .wr_addr (fill_reg[ADDR_BITS-1:0]),
        .wr_data ({key_reg, acc_len_reg, acc_cnt_reg}),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_BITS-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            best_len_reg  <= '0;
            best_cnt_reg  <= '0;
            sat_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_en;
            cmp_valid_reg <= rd_valid_reg;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (fill_reg == '0 || store_full)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (cmp_valid_reg && cmp_hit_reg && cmp_len_reg == acc_len_reg
                        && acc_sum[COUNT_BITS])
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (fin_fire)
                    begin
                        state_reg <= ST_IDLE;
                        if (last_reg)
                        begin
                            fill_reg     <= '0;
                            best_len_reg <= '0;
                            best_cnt_reg <= '0;
                            sat_reg      <= 1'b0;
                            ovf_reg      <= 1'b0;
                        end
                        else
                        begin
                            if (!store_full)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            best_len_reg <= best_len_next;
                            best_cnt_reg <= best_cnt_next;
                            sat_reg      <= sat_next;
                            ovf_reg      <= ovf_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (fin_fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg     <= in_key;
            last_reg    <= s_tlast;
            idx_reg     <= '0;
            acc_len_reg <= LEN_BITS'(1);
            acc_cnt_reg <= COUNT_BITS'(1);
        end
        else
        begin
            if (rd_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmp_valid_reg && cmp_hit_reg)
            begin
                if (cmp_len_reg > acc_len_reg)
                begin
                    acc_len_reg <= cmp_len_reg;
                    acc_cnt_reg <= cmp_cnt_reg;
                end
                else if (cmp_len_reg == acc_len_reg)
                begin
                    acc_cnt_reg <= acc_sum[COUNT_BITS] ? CNT_MAX : acc_sum[COUNT_BITS-1:0];
                end
            end
        end

        cmp_hit_reg <= (rd_key < key_reg);
        cmp_len_reg <= rd_len + 1'b1;
        cmp_cnt_reg <= rd_cnt;

        if (fin_fire)
        begin
            out_len_reg  <= best_len_next;
            out_cnt_reg  <= best_cnt_next;
            out_sat_reg  <= sat_next;
            out_ovf_reg  <= ovf_next;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_cnt_reg, out_len_reg});
    assign m_tuser[USER_SAT_BIT] = out_sat_reg;
    assign m_tuser[USER_OVF_BIT] = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/lirc_entry_ram.sv
// Single-port-write, single-port-read entry memory with a registered read.
// Stores one packed entry per sequence position; depends on nothing.
`default_nettype none

module lirc_entry_ram #(
    parameter int unsigned ADDR_BITS = 11,
    parameter int unsigned DATA_BITS = 76
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lirc_checker.sv
// Port-level checker for the longest increasing run counter, bound to the top level.
// Depends on lirc_pkg; watches the stream ports only.
`default_nettype none

module lirc_checker
    import lirc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS  = 2048,
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned COUNT_BITS = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input wire logic s_tlast,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [(($clog2(MAX_ITEMS + 1) + COUNT_BITS + 7) / 8) * 8-1:0] m_tdata,
    input wire logic [USER_BITS-1:0] m_tuser,
    input wire logic m_tlast
);

    localparam int unsigned LEN_BITS = $clog2(MAX_ITEMS + 1);

    logic [LEN_BITS-1:0]   chk_len;
    logic [COUNT_BITS-1:0] chk_cnt;

    assign chk_len = m_tdata[LEN_BITS-1:0];
    assign chk_cnt = m_tdata[LEN_BITS+COUNT_BITS-1:LEN_BITS];

    // A stalled answer keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
    else $error("Stalled output transaction changed.");

    // A waiting input transaction keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
    else $error("Waiting input transaction changed.");

    // Every accepted item keeps the block busy for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted in two consecutive cycles.");

    // A nonzero longest length always has at least one subsequence behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && chk_len != '0 |-> chk_cnt != '0)
    else $error("Longest length reported with zero count.");

    // An overflow means the store was full, so the longest length cannot be zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_OVF_BIT] |-> chk_len != '0)
    else $error("Store overflow reported with an empty answer.");

endmodule

bind longest_increasing_run_counter lirc_checker #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_lirc_checker (.*);

`default_nettype wire

FILE: test/lirc_answer_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the longest increasing run counter, predicts every answer
// and compares it field by field. Depends on lirc_pkg for the tuser bit positions.
module lirc_answer_checker
    import lirc_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 2048
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [31:0]          s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [47:0]          m_tdata,
    input  wire logic [USER_BITS-1:0] m_tuser,
    input  wire logic                 m_tlast,
    output int                        errors,
    output int                        pending
);

    localparam int LEN_BITS = 12;
    localparam int CNT_BITS = 32;

    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        logic [CNT_BITS-1:0] cnt;
        logic                sat;
        logic                ovf;
        logic                fin;
    } run_answer_t;

    logic signed [31:0]  value_mem [MAX_ENTRIES];
    logic [LEN_BITS-1:0] len_mem [MAX_ENTRIES];
    logic [CNT_BITS-1:0] cnt_mem [MAX_ENTRIES];
    int unsigned         fill;
    logic [LEN_BITS-1:0] best_len;
    logic [CNT_BITS-1:0] best_cnt;
    logic                sat_seen;
    logic                ovf_seen;
    run_answer_t         answers [$];
    run_answer_t         want;

    task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, exp_val, got_val);
        errors++;
    endtask

    function automatic logic [CNT_BITS-1:0] clip_add(input logic [CNT_BITS-1:0] a,
                                                     input logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[CNT_BITS]) begin
            sat_seen = 1'b1;
            return '1;
        end
        return sum[CNT_BITS-1:0];
    endfunction

    task automatic clear_run();
        fill     = 0;
        best_len = '0;
        best_cnt = '0;
        sat_seen = 1'b0;
        ovf_seen = 1'b0;
    endtask

    task automatic take_value(input logic signed [31:0] v, input logic fin);
        logic [LEN_BITS-1:0] len;
        logic [LEN_BITS-1:0] cand;
        logic [CNT_BITS-1:0] cnt;
        run_answer_t         ans;
        int unsigned         j;
        if (fill >= MAX_ENTRIES) begin
            ovf_seen = 1'b1;
        end
        else begin
            len = LEN_BITS'(1);
            cnt = CNT_BITS'(1);
            for (j = 0; j < fill; j++) begin
                if (value_mem[j] < v) begin
                    cand = len_mem[j] + 1'b1;
                    if (cand > len) begin
                        len = cand;
                        cnt = cnt_mem[j];
                    end
                    else if (cand == len) begin
                        cnt = clip_add(cnt, cnt_mem[j]);
                    end
                end
            end
            if (len > best_len) begin
                best_len = len;
                best_cnt = cnt;
            end
            else if (len == best_len) begin
                best_cnt = clip_add(best_cnt, cnt);
            end
            value_mem[fill] = v;
            len_mem[fill]   = len;
            cnt_mem[fill]   = cnt;
            fill++;
        end
        ans.len = best_len;
        ans.cnt = best_cnt;
        ans.sat = sat_seen;
        ans.ovf = ovf_seen;
        ans.fin = fin;
        answers.push_back(ans);
        if (fin) begin
            clear_run();
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            clear_run();
            answers.delete();
        end
        else begin
            if (s_tvalid && s_tready) begin
                take_value($signed(s_tdata), s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    report_mismatch("unexpected result transaction", 32'd0, 32'd1);
                end
                else begin
                    want = answers.pop_front();
                    if (m_tdata[LEN_BITS-1:0] !== want.len)
                        report_mismatch("longest_len", 32'(want.len),
                                        32'(m_tdata[LEN_BITS-1:0]));
                    if (m_tdata[LEN_BITS +: CNT_BITS] !== want.cnt)
                        report_mismatch("longest_count", want.cnt, m_tdata[LEN_BITS +: CNT_BITS]);
                    if (m_tuser[USER_SAT_BIT] !== want.sat)
                        report_mismatch("count_saturated", 32'(want.sat),
                                        32'(m_tuser[USER_SAT_BIT]));
                    if (m_tuser[USER_OVF_BIT] !== want.ovf)
                        report_mismatch("store_overflow", 32'(want.ovf),
                                        32'(m_tuser[USER_OVF_BIT]));
                    if (m_tlast !== want.fin)
                        report_mismatch("final_answer", 32'(want.fin), 32'(m_tlast));
                end
            end
        end
        pending = answers.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the longest increasing run counter: clock, reset, stimulus under
// several idle settings, and the verdict. Needs lirc_pkg, the DUT and lirc_answer_checker.
module tb;
    import lirc_pkg::*;

    localparam int MAX_ENTRIES = 2048;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_ITEMS = 72;
    localparam longint CYCLE_LIMIT = 12_000_000;

    typedef enum int {MIX_TIGHT, MIX_WIDE, MIX_RISING} value_mix_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [47:0]          m_tdata;
    logic [USER_BITS-1:0] m_tuser;
    logic                 m_tlast;

    int     check_errors;
    int     pending;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_request;
    int     hold_left;
    longint cycle_count;

    longest_increasing_run_counter DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lirc_answer_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (check_errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random, or holds off for a long stretch when asked.
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_value(input logic [31:0] v, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_sequence(input int n, input value_mix_t mix);
        logic [31:0] v;
        logic [31:0] base;
        int          i;
        base = $urandom;
        for (i = 0; i < n; i++)
        begin
            case (mix)
                MIX_TIGHT:  v = 32'(int'($urandom_range(0, 16)) - 8);
                MIX_WIDE:   v = $urandom;
                default:
                begin
                    base = base + $urandom_range(0, 6) - 2;
                    v    = base;
                end
            endcase
            if ($urandom_range(0, 19) == 0)
                v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            offer_value(v, i == n - 1);
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        int sent;
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
            send_sequence(n, value_mix_t'($urandom_range(0, 2)));
            sent += n;
        end
    endtask

    initial
    begin
        int i;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        cycle_count    = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Value extremes, a single-item sequence, ties, a falling run and a mixed run.
        offer_value(32'h8000_0000, 1'b0);
        offer_value(32'h7FFF_FFFF, 1'b1);
        offer_value(32'd5, 1'b1);
        for (i = 0; i < 4; i++)
            offer_value(32'd3, i == 3);
        for (i = 0; i < 5; i++)
            offer_value(32'(10 - i), i == 4);
        offer_value(32'd1, 1'b0);
        offer_value(32'd3, 1'b0);
        offer_value(32'd2, 1'b0);
        offer_value(32'd4, 1'b0);
        offer_value(32'hFFFF_FFFF, 1'b0);
        offer_value(32'd0, 1'b0);
        offer_value(32'd4, 1'b0);
        offer_value(32'd7, 1'b1);

        // Each rising pair doubles the count, so it clips after 32 pairs.
        for (i = 0; i < 36; i++)
        begin
            offer_value(32'(2 * i + 1), 1'b0);
            offer_value(32'(2 * i), i == 35);
        end

        // A strictly rising run fills the store; the items after it are dropped.
        for (i = 0; i < MAX_ENTRIES; i++)
            offer_value(32'h8000_0000 + (32'(i) << 21) + $urandom_range(0, 32'h1F_FFFF), 1'b0);
        for (i = 0; i < 3; i++)
            offer_value($urandom, i == 2);

        hold_request = 1'b1;
        random_phase(0, 0);
        random_phase(77, 0);
        random_phase(0, 77);
        random_phase(36, 36);
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
        if (check_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
